// ===== rtl/bubble_sort_engine_assert.svh =====
// ----------------------------------------------------------------------------
// bubble_sort_engine assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_ASSERT_SVH

// check cons in the same cycle as ante
`define BSE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define BSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types of the bubble sort engine: controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_CHECK,
        ST_RD0,
        ST_RD1,
        ST_CMP,
        ST_FLUSH,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } bse_state_t;

    typedef struct packed {
        logic store;
        logic init;
        logic rd0;
        logic rd1;
        logic step;
        logic flush;
        logic emit_rd;
        logic emit_ld;
        logic emit_done;
    } bse_cmd_t;

    typedef struct packed {
        logic range_gt1;
        logic pass_end;
        logic emit_last;
    } bse_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl
// Controller: sequences load, sort passes and emission of the sorted words.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ctrl
    import bse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    input  wire logic      s_tlast,
    input  wire logic      m_tready,
    input  wire bse_stat_t stat,
    output bse_cmd_t       cmd,
    output logic           s_tready,
    output logic           m_tvalid
);

    bse_state_t state_reg;
    bse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = stat.range_gt1 ? ST_RD0 : ST_EMIT_RD;
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.pass_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_CHECK;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (m_tready)
                begin
                    state_next = stat.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready  = 1'b1;
                cmd.store = s_tvalid;
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
            end
            ST_RD0:
            begin
                cmd.rd0 = 1'b1;
            end
            ST_RD1:
            begin
                cmd.rd1 = 1'b1;
            end
            ST_CMP:
            begin
                cmd.step = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_ld = 1'b1;
            end
            ST_EMIT_HOLD:
            begin
                m_tvalid      = 1'b1;
                cmd.emit_done = m_tready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bse_dp.sv =====
// ----------------------------------------------------------------------------
// bse_dp
// Datapath: element memory, counters, carry register and compare for the
// bubble passes, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_dp
    import bse_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bse_cmd_t          cmd,
    input  wire logic [DATA_W-1:0] in_value,
    output bse_stat_t              stat,
    output logic [DATA_W-1:0]      out_value,
    output logic                   out_last,
    output logic                   out_ovf
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [CW-1:0]     range_reg;
    logic [CW-1:0]     range_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     idx_next;
    logic [AW-1:0]     k_reg;
    logic [AW-1:0]     k_next;
    logic [DATA_W-1:0] carry_reg;
    logic [DATA_W-1:0] carry_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic              full;
    logic              gt;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;

    assign full = (count_reg == CW'(DEPTH));
    assign gt   = ($signed(carry_reg) > $signed(rdata_reg));

    assign stat.range_gt1 = (range_reg > CW'(1));
    assign stat.pass_end  = ((CW'(idx_reg) + CW'(1)) == (range_reg - CW'(1)));
    assign stat.emit_last = ((CW'(k_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = carry_reg;
        if (cmd.store && !full)
        begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = in_value;
        end
        else if (cmd.step)
        begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = gt ? rdata_reg : carry_reg;
        end
        else if (cmd.flush)
        begin
            we    = 1'b1;
            waddr = AW'(range_reg - CW'(1));
            wdata = carry_reg;
        end
    end

    always_comb
    begin
        raddr = '0;
        if (cmd.rd0)
        begin
            raddr = '0;
        end
        else if (cmd.rd1)
        begin
            raddr = AW'(1);
        end
        else if (cmd.step)
        begin
            raddr = idx_reg + AW'(2);
        end
        else if (cmd.emit_rd)
        begin
            raddr = k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        range_next = range_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        carry_next = carry_reg;
        if (cmd.store)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.init)
        begin
            range_next = count_reg;
            k_next     = '0;
        end
        if (cmd.rd1)
        begin
            carry_next = rdata_reg;
            idx_next   = '0;
        end
        if (cmd.step)
        begin
            idx_next = idx_reg + AW'(1);
            if (!gt)
            begin
                carry_next = rdata_reg;
            end
        end
        if (cmd.flush)
        begin
            range_next = range_reg - CW'(1);
        end
        if (cmd.emit_done)
        begin
            if (stat.emit_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                k_next     = '0;
            end
            else
            begin
                k_next = k_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            range_reg <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            range_reg <= range_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.emit_ld)
        begin
            out_value_reg <= rdata_reg;
            out_last_reg  <= stat.emit_last;
        end
    end

    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/bubble_sort_engine.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine
// Collects signed 32-bit words up to the one marked last, bubble-sorts them
// in place and streams them back in ascending order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tlast    | tuser
//  s_*     | in  | [31:0] value     | last_in  | -
//  m_*     | out | [31:0] sorted    | last_out | overflowed
//
//  Load: one word per cycle; words past DEPTH are dropped and flagged.
//  Sort: one compare-and-write per cycle on the single memory write port.
//  Emit: each word is read, registered and held till taken; s_tready stays low
//  from the last input word until the last output word is taken.
//  Reset clears counters and the controller; memory contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module bubble_sort_engine
    import bse_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // [31:0] sorted_value
    output logic                   m_tlast,
    output logic                   m_tuser    // [0] overflowed
);

    bse_cmd_t  cmd;
    bse_stat_t stat;

    bse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    bse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_value  (s_tdata),
        .stat      (stat),
        .out_value (m_tdata),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

`include "bubble_sort_engine_assert.svh"

    `BSE_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input and output open together")
    `BSE_ASSERT_NEXT(a_close_set, s_tvalid && s_tready && s_tlast, !s_tready, "set not closed")
    `BSE_ASSERT_NEXT(a_reopen, m_tvalid && m_tready && m_tlast, s_tready, "input not reopened")

endmodule

`default_nettype wire
